// ===== design/pulse_counter_period_average_defines.svh =====
// Assertion macros shared by the pulse counter RTL files.
`ifndef PULSE_COUNTER_PERIOD_AVERAGE_DEFINES_SVH
`define PULSE_COUNTER_PERIOD_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define PCA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pulse counter assertion failed");
// Check a property on every rising edge, reset included.
`define PCA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pulse counter reset assertion failed");
`else
`define PCA_ASSERT(lbl, clk, rst_n, prop)
`define PCA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/pca_pkg.sv =====
// Types and constants shared by the pulse counter modules.
package pca_pkg;

  localparam int TIME_WIDTH  = 48;
  localparam int COUNT_WIDTH = 32;
  localparam int READ_WIDTH  = 48;
  localparam int CMD_WIDTH   = 3;

  // Input tdata layout, lowest bit first: cmd, timestamp_us, write_value
  localparam int TS_LSB         = CMD_WIDTH;
  localparam int WV_LSB         = CMD_WIDTH + TIME_WIDTH;
  localparam int IN_TDATA_WIDTH = ((CMD_WIDTH + TIME_WIDTH + COUNT_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = ((READ_WIDTH + 7) / 8) * 8;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_PULSE      = 3'd0,
    CMD_READ_COUNT = 3'd1,
    CMD_WRITE_COUNT = 3'd2,
    CMD_READ_LAST  = 3'd3,
    CMD_CLEAR_LAST = 3'd4,
    CMD_READ_AVG   = 3'd5,
    CMD_CLEAR_AVG  = 3'd6
  } cmd_t;

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [READ_WIDTH-1:0]  rdata_t;

  typedef struct packed {
    count_t write_value;
    time_t  timestamp_us;
    cmd_t   cmd;
  } item_t;

  // Handshake between the input stage, the core and the output stage
  typedef struct packed {
    logic fire;     // held item moves through the core this cycle
    logic advance;  // output stage can take a result this cycle
  } flow_t;

endpackage

// ===== design/pulse_counter_period_average.sv =====
// Top level of the pulse counter with period measurement.
//
//   Port group   Dir   Carries
//   in_*         in    command items: cmd, timestamp_us, write_value
//   out_*        out   one result item per command: read_data
//   cfg_*        in    clear_on_read register write
//
// One item per cycle sustained while out_tready stays high; an accepted
// item passes the input register, then decode and state update into the
// output register, where out_tvalid rises.
// Reset (rst_n low, synchronous) clears the count, periods, flags and both
// stage valid bits.
// A stalled output holds its result; the input register still takes one
// more item, after which in_tready follows out_tready.
`include "pulse_counter_period_average_defines.svh"

module pulse_counter_period_average (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // cmd [2:0], timestamp_us [50:3], write_value [82:51], zero pad
  input  logic [pca_pkg::IN_TDATA_WIDTH-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // read_data [47:0]
  output logic [pca_pkg::OUT_TDATA_WIDTH-1:0]  out_tdata,
  input  logic                                 cfg_wen,
  input  logic                                 cfg_wdata
);

  pca_pkg::item_t  in_item;
  pca_pkg::item_t  item_r;
  pca_pkg::flow_t  flow;
  pca_pkg::rdata_t read_data;
  pca_pkg::rdata_t out_data_r;
  logic            in_valid_r;

  // Unpack the input item
  assign in_item.cmd          = pca_pkg::cmd_t'(in_tdata[pca_pkg::CMD_WIDTH-1:0]);
  assign in_item.timestamp_us = in_tdata[pca_pkg::TS_LSB +: pca_pkg::TIME_WIDTH];
  assign in_item.write_value  = in_tdata[pca_pkg::WV_LSB +: pca_pkg::COUNT_WIDTH];

  // Advance when the output stage is free or being drained
  assign flow.advance = !out_tvalid || out_tready;
  assign flow.fire    = in_valid_r && flow.advance;

  pca_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .flow      (flow),
    .valid_r   (in_valid_r),
    .item_r    (item_r)
  );

  pca_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .flow      (flow),
    .item      (item_r),
    .read_data (read_data)
  );

  pca_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .flow       (flow),
    .read_data  (read_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .data_r     (out_data_r)
  );

  assign out_tdata = pca_pkg::OUT_TDATA_WIDTH'(out_data_r);

  `PCA_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!out_tvalid && in_tready))
  `PCA_ASSERT(a_full_blocks_input, clk, rst_n, (in_valid_r && out_tvalid && !out_tready) |-> !in_tready)
  `PCA_ASSERT(a_fire_gives_result, clk, rst_n, flow.fire |=> out_tvalid)

endmodule

// ===== design/pca_in_reg.sv =====
// Input register: holds one accepted item until the core consumes it.
module pca_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  pca_pkg::item_t in_item,
  input  pca_pkg::flow_t flow,
  output logic           valid_r,
  output pca_pkg::item_t item_r
);

  logic valid_nxt;
  logic take;

  // Take a new item when empty or when the held one leaves this cycle
  assign in_tready = !valid_r || flow.advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (flow.fire) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold valid flag; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== design/pca_core.sv =====
// Counter and period state with the combinational command decode.
`include "pulse_counter_period_average_defines.svh"

module pca_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wen,
  input  logic           cfg_wdata,
  input  pca_pkg::flow_t flow,
  input  pca_pkg::item_t item,
  output pca_pkg::rdata_t read_data
);

  logic            clear_on_read_r;
  pca_pkg::count_t pulse_total_r, pulse_total_nxt;
  pca_pkg::time_t  prev_ts_r, prev_ts_nxt;
  logic            have_prev_r, have_prev_nxt;
  pca_pkg::time_t  last_r, last_nxt;
  pca_pkg::time_t  avg_r, avg_nxt;
  pca_pkg::time_t  period;
  pca_pkg::time_t  half_sum;

  // Measured period, clamped to zero for a timestamp that went back
  assign period = (item.timestamp_us >= prev_ts_r) ?
                  (item.timestamp_us - prev_ts_r) : '0;

  // floor((avg + period) / 2) without a carry bit
  assign half_sum = (avg_r >> 1) + (period >> 1) +
                    pca_pkg::time_t'(avg_r[0] & period[0]);

  // Decode the command and form next state and read data
  always_comb begin
    pulse_total_nxt = pulse_total_r;
    prev_ts_nxt     = prev_ts_r;
    have_prev_nxt   = have_prev_r;
    last_nxt        = last_r;
    avg_nxt         = avg_r;
    read_data       = '0;
    unique case (item.cmd)
      pca_pkg::CMD_PULSE: begin
        pulse_total_nxt = pulse_total_r + 1'b1;
        if (have_prev_r) begin
          last_nxt = period;
          avg_nxt  = (avg_r == '0) ? period : half_sum;
        end
        prev_ts_nxt   = item.timestamp_us;
        have_prev_nxt = 1'b1;
      end
      pca_pkg::CMD_READ_COUNT: begin
        read_data = pca_pkg::rdata_t'(pulse_total_r);
        if (clear_on_read_r) begin
          pulse_total_nxt = '0;
        end
      end
      pca_pkg::CMD_WRITE_COUNT: pulse_total_nxt = item.write_value;
      pca_pkg::CMD_READ_LAST:   read_data = pca_pkg::rdata_t'(last_r);
      pca_pkg::CMD_CLEAR_LAST:  last_nxt = '0;
      pca_pkg::CMD_READ_AVG:    read_data = pca_pkg::rdata_t'(avg_r);
      pca_pkg::CMD_CLEAR_AVG:   avg_nxt = '0;
      default: ;
    endcase
  end

  // Update counter and period state only when an item passes through; clear_on_read loads on cfg_wen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_on_read_r <= 1'b0;
      pulse_total_r   <= '0;
      prev_ts_r       <= '0;
      have_prev_r     <= 1'b0;
      last_r          <= '0;
      avg_r           <= '0;
    end else begin
      if (cfg_wen) begin
        clear_on_read_r <= cfg_wdata;
      end
      if (flow.fire) begin
        pulse_total_r <= pulse_total_nxt;
        prev_ts_r     <= prev_ts_nxt;
        have_prev_r   <= have_prev_nxt;
        last_r        <= last_nxt;
        avg_r         <= avg_nxt;
      end
    end
  end

  `PCA_ASSERT(a_pulse_sets_prev, clk, rst_n, (flow.fire && item.cmd == pca_pkg::CMD_PULSE) |=> have_prev_r)
  `PCA_ASSERT(a_avg_nonzero, clk, rst_n, (flow.fire && item.cmd == pca_pkg::CMD_PULSE && have_prev_r && item.timestamp_us > prev_ts_r) |=> (avg_r != '0))
  `PCA_ASSERT(a_clear_on_read, clk, rst_n, (flow.fire && item.cmd == pca_pkg::CMD_READ_COUNT && clear_on_read_r && !cfg_wen) |=> (pulse_total_r == '0))

endmodule

// ===== design/pca_out_reg.sv =====
// Output register: holds one result until the downstream side takes it.
module pca_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  pca_pkg::flow_t  flow,
  input  pca_pkg::rdata_t read_data,
  output logic            out_tvalid,
  input  logic            out_tready,
  output pca_pkg::rdata_t data_r
);

  logic valid_r, valid_nxt;

  assign out_tvalid = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (flow.fire) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold the result; load a new one whenever an item passes the core
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (flow.fire) begin
      data_r <= read_data;
    end
  end

endmodule
